/* src/spq_pkg.sv */
package spq_pkg;

	localparam int unsigned PrioW        = 16;
	localparam int unsigned TagW         = 4;
	localparam int unsigned OccW         = 4;
	localparam int unsigned StatusW      = 2;
	localparam int unsigned DepthDefault = 8;

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_REMOVE = 1'b1
	} func_t;

	typedef enum logic [StatusW-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [PrioW-1:0] prio;
		logic [TagW-1:0]  tag;
	} spq_entry_t;

	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [PrioW-1:0] prio;
		logic [TagW-1:0]  tag;
	} spq_ctl_t;

endpackage

/* src/spq_req_if.sv */
interface spq_req_if import spq_pkg::*; ();

	logic             valid;
	logic             ready;
	logic             func;
	logic [PrioW-1:0] priority_req;

	modport source (output valid, output func, output priority_req, input ready);
	modport sink (input valid, input func, input priority_req, output ready);

endinterface

/* src/spq_rsp_if.sv */
interface spq_rsp_if import spq_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [StatusW-1:0] status;
	logic [PrioW-1:0]   removed_priority;
	logic [TagW-1:0]    removed_tag;
	logic [OccW-1:0]    occupancy;

	modport source (
		output valid, output status, output removed_priority,
		output removed_tag, output occupancy, input ready
	);
	modport sink (
		input valid, input status, input removed_priority,
		input removed_tag, input occupancy, output ready
	);

endinterface

/* src/sorted_priority_queue.sv */
// Channel  Dir  Modport  Payload
// req      in   sink     func, priority_req
// rsp      out  source   status, removed_priority, removed_tag, occupancy
//
// One request per cycle: every cell compares and shifts in the same cycle.
// The response is registered and valid in the cycle after acceptance;
// req.ready is high while that register is empty or being taken, so a
// stalled rsp stalls req. Reset clears the occupancy count and the
// response valid; cell contents stay undefined until written.
module sorted_priority_queue import spq_pkg::*; #(
	parameter int unsigned DEPTH = DepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);

	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [CntW-1:0] Full = CntW'(DEPTH);

	logic [CntW-1:0]  count_q;
	logic [CntW-1:0]  count_next;
	logic             rsp_valid_q;
	status_t          status_q;
	logic [PrioW-1:0] rprio_q;
	logic [TagW-1:0]  rtag_q;
	logic [OccW-1:0]  occ_q;

	logic       acc;
	logic       is_full;
	logic       is_empty;
	spq_ctl_t   ctl;
	spq_entry_t ent [DEPTH];
	logic       gt  [DEPTH];

	assign is_full  = count_q == Full;
	assign is_empty = count_q == '0;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;

	assign ctl.ins  = acc && (req.func == FUNC_INSERT) && !is_full;
	assign ctl.rem  = acc && (req.func == FUNC_REMOVE) && !is_empty;
	assign ctl.prio = req.priority_req;
	assign ctl.tag  = TagW'(count_q + CntW'(1));

	always_comb begin
		count_next = count_q;
		if (ctl.ins) begin
			count_next = count_q + CntW'(1);
		end else if (ctl.rem) begin
			count_next = count_q - CntW'(1);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_entry_t left_ent;
		spq_entry_t right_ent;
		logic       left_gt;

		if (i == 0) begin : g_head
			assign left_ent = '0;
			assign left_gt  = 1'b0;
		end else begin : g_mid
			assign left_ent = ent[i-1];
			assign left_gt  = gt[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_ent = '0;
		end else begin : g_next
			assign right_ent = ent[i+1];
		end

		spq_cell #(
			.Idx  (i),
			.CntW (CntW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count_q),
			.left_ent  (left_ent),
			.left_gt   (left_gt),
			.right_ent (right_ent),
			.ent       (ent[i]),
			.gt        (gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			occ_q   <= OccW'(count_next);
			rprio_q <= '0;
			rtag_q  <= '0;
			if (req.func == FUNC_INSERT) begin
				status_q <= is_full ? ST_FULL : ST_DONE;
			end else if (is_empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_DONE;
				rprio_q  <= ent[0].prio;
				rtag_q   <= ent[0].tag;
			end
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = status_q;
	assign rsp.removed_priority = rprio_q;
	assign rsp.removed_tag      = rtag_q;
	assign rsp.occupancy        = occ_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Full)
		else $error("occupancy above depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + CntW'(1))
		else $error("insert did not grow occupancy");

	a_rsp_occ: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> rsp_valid_q && (occ_q == OccW'(count_q)))
		else $error("response occupancy mismatch");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CntW'(2)) |-> (ent[0].prio <= ent[1].prio))
		else $error("head entries out of order");
`endif

endmodule

/* src/spq_cell.sv */
module spq_cell import spq_pkg::*; #(
	parameter int unsigned Idx  = 0,
	parameter int unsigned CntW = 4
) (
	input  logic            clk,
	input  spq_ctl_t        ctl,
	input  logic [CntW-1:0] count,
	input  spq_entry_t      left_ent,
	input  logic            left_gt,
	input  spq_entry_t      right_ent,
	output spq_entry_t      ent,
	output logic            gt
);

	localparam logic [CntW-1:0] IdxC = CntW'(Idx);

	spq_entry_t ent_q;
	spq_entry_t new_ent;
	logic       held;

	assign held    = IdxC < count;
	assign gt      = !held || (ent_q.prio > ctl.prio);
	assign new_ent = '{prio: ctl.prio, tag: ctl.tag};
	assign ent     = ent_q;

	always_ff @(posedge clk) begin
		priority if (ctl.ins && gt) begin
			ent_q <= left_gt ? left_ent : new_ent;
		end else if (ctl.rem) begin
			ent_q <= right_ent;
		end
	end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import spq_pkg::*;

	typedef struct {
		func_t            func;
		logic [PrioW-1:0] prio;
		bit               drain_first;
	} spq_request_t;

	typedef struct {
		status_t          status;
		logic [PrioW-1:0] prio;
		logic [TagW-1:0]  tag;
		logic [OccW-1:0]  occ;
	} spq_outcome_t;

	logic clk = 1'b0;
	logic arst_n;

	spq_req_if req_if ();
	spq_rsp_if rsp_if ();

	sorted_priority_queue u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #5 clk = ~clk;

	spq_request_t request_backlog[$];
	spq_outcome_t expected_outcomes[$];
	spq_entry_t   held_entries[$];

	int unsigned mismatch_cnt = 0;
	int unsigned requests_sent = 0;
	int unsigned outcomes_seen = 0;
	int unsigned send_wait = 0;
	int unsigned take_wait = 0;
	bit          send_brisk = 1'b0;
	bit          take_brisk = 1'b0;

	function automatic void queue_apply(input func_t f, input logic [PrioW-1:0] p);
		spq_outcome_t o;
		spq_entry_t   e;
		int           pos;
		o.status = ST_DONE;
		o.prio   = '0;
		o.tag    = '0;
		if (f == FUNC_INSERT) begin
			if (held_entries.size() >= DepthDefault) begin
				o.status = ST_FULL;
			end else begin
				e.prio = p;
				e.tag  = TagW'(held_entries.size() + 1);
				pos = 0;
				while (pos < held_entries.size() && held_entries[pos].prio <= p)
					pos++;
				held_entries.insert(pos, e);
			end
		end else begin
			if (held_entries.size() == 0) begin
				o.status = ST_EMPTY;
			end else begin
				e = held_entries.pop_front();
				o.prio = e.prio;
				o.tag  = e.tag;
			end
		end
		o.occ = OccW'(held_entries.size());
		expected_outcomes.push_back(o);
	endfunction

	function automatic void check_outcome();
		spq_outcome_t exp_o;
		if (expected_outcomes.size() == 0) begin
			if (mismatch_cnt < 10)
				$display("%0t: response with none outstanding: status %0d prio %h tag %0d occ %0d",
					$realtime, rsp_if.status, rsp_if.removed_priority,
					rsp_if.removed_tag, rsp_if.occupancy);
			mismatch_cnt++;
			return;
		end
		exp_o = expected_outcomes.pop_front();
		if (rsp_if.status !== exp_o.status || rsp_if.removed_priority !== exp_o.prio ||
			rsp_if.removed_tag !== exp_o.tag || rsp_if.occupancy !== exp_o.occ) begin
			if (mismatch_cnt < 10)
				$display("%0t: mismatch exp status %0d prio %h tag %0d occ %0d, got status %0d prio %h tag %0d occ %0d",
					$realtime, exp_o.status, exp_o.prio, exp_o.tag, exp_o.occ,
					rsp_if.status, rsp_if.removed_priority, rsp_if.removed_tag,
					rsp_if.occupancy);
			mismatch_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid        <= 1'b0;
			req_if.func         <= FUNC_INSERT;
			req_if.priority_req <= '0;
			send_wait = 0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				queue_apply(func_t'(req_if.func), req_if.priority_req);
				requests_sent++;
			end
			if (req_if.valid && !req_if.ready) begin
				// hold the request until taken
			end else if (send_wait > 0) begin
				send_wait--;
				req_if.valid <= 1'b0;
			end else if (request_backlog.size() > 0 &&
				!(request_backlog[0].drain_first && outcomes_seen != requests_sent)) begin
				req_if.valid        <= 1'b1;
				req_if.func         <= request_backlog[0].func;
				req_if.priority_req <= request_backlog[0].prio;
				void'(request_backlog.pop_front());
				send_wait = send_brisk ? 0 : $urandom_range(0, 14);
				if ($urandom_range(0, 19) == 0)
					send_brisk = !send_brisk;
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			take_wait = 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				check_outcome();
				outcomes_seen <= outcomes_seen + 1;
				take_wait = take_brisk ? 0 : $urandom_range(0, 14);
				if ($urandom_range(0, 19) == 0)
					take_brisk = !take_brisk;
			end else if (take_wait > 0) begin
				take_wait--;
			end
			rsp_if.ready <= (take_wait == 0);
		end
	end

	function automatic void add_request(input func_t f, input logic [PrioW-1:0] p,
		input bit drain);
		spq_request_t r;
		r.func        = f;
		r.prio        = p;
		r.drain_first = drain;
		request_backlog.push_back(r);
	endfunction

	function automatic logic [PrioW-1:0] draw_priority(input bit narrow);
		if (narrow)
			return PrioW'(16'h7FFC + $urandom_range(0, 7));
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PrioW'($urandom());
		endcase
	endfunction

	initial begin
		int unsigned total;
		int unsigned span;
		int unsigned ins_pct;
		bit          narrow;
		arst_n = 1'b0;

		add_request(FUNC_REMOVE, 16'h1234, 1'b0);
		add_request(FUNC_INSERT, 16'h0000, 1'b0);
		add_request(FUNC_INSERT, 16'hFFFF, 1'b0);
		add_request(FUNC_INSERT, 16'h8000, 1'b0);
		add_request(FUNC_INSERT, 16'h8000, 1'b0);
		add_request(FUNC_INSERT, 16'h7FFF, 1'b0);
		add_request(FUNC_INSERT, 16'h0000, 1'b0);
		add_request(FUNC_INSERT, 16'hFFFF, 1'b0);
		add_request(FUNC_INSERT, 16'h5555, 1'b0);
		add_request(FUNC_INSERT, 16'hAAAA, 1'b0);
		for (int i = 0; i < DepthDefault; i++)
			add_request(FUNC_REMOVE, 16'hFFFF, 1'b0);
		add_request(FUNC_REMOVE, 16'h0000, 1'b1);
		add_request(FUNC_INSERT, 16'hFFFF, 1'b0);
		add_request(FUNC_REMOVE, 16'h0000, 1'b0);

		total = 0;
		while (total < 630) begin
			case ($urandom_range(0, 2))
				0: ins_pct = 15;
				1: ins_pct = 50;
				default: ins_pct = 85;
			endcase
			narrow = ($urandom_range(0, 2) == 0);
			span = $urandom_range(8, 40);
			for (int k = 0; k < span; k++) begin
				add_request(($urandom_range(0, 99) < ins_pct) ? FUNC_INSERT : FUNC_REMOVE,
					draw_priority(narrow), k == 0 && $urandom_range(0, 3) == 0);
				total++;
			end
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (request_backlog.size() != 0 || req_if.valid || expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("sorted_priority_queue verification clean");
		else
			$display("sorted_priority_queue verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("sorted_priority_queue verification failed");
		$finish;
	end

endmodule
